>>> src/sfh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sound file header checker.
// Used by sfh_track and sound_file_header_check_minmax; no dependencies.
package sfh_pkg;

   localparam int CountWidth = 17;

   // Byte counter saturation point and the largest legal file size.
   localparam logic [CountWidth-1:0] BYTES_SAT    = 17'h10004;
   localparam logic [CountWidth-1:0] SIZE_MAX_OK  = 17'h10003;
   localparam logic [CountWidth-1:0] HEADER_BYTES = 17'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_SIZE  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
   localparam logic [1:0] STATUS_TRAILING  = 2'd3;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [15:0]       sample_count;
      logic [1:0]        trailing_count;
      logic signed [7:0] min_sample;
      logic signed [7:0] max_sample;
   } rsp_type;

endpackage

>>> src/sfh_track.sv
`timescale 1ns / 1ps
// Per-file state (byte count, header length, sample min/max) and result build.
// Depends on sfh_pkg.
module sfh_track import sfh_pkg::*; #(
   parameter int MAX_TRAILING = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   output rsp_type result
);

   logic [CountWidth-1:0] bytes_seen_ff, bytes_seen_in;
   logic [15:0]           header_ff, header_in;
   logic signed [7:0]     min_ff, min_in;
   logic signed [7:0]     max_ff, max_in;
   logic [CountWidth-1:0] sample_end;
   logic [CountWidth-1:0] trail_full;
   logic signed [7:0]     sample;

   assign sample     = $signed(item.file_byte);
   assign sample_end = {1'b0, header_in} + HEADER_BYTES;
   assign trail_full = bytes_seen_in - sample_end;

   always_comb begin
      header_in = header_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      if (bytes_seen_ff == '0) begin
         header_in[15:8] = item.file_byte;
      end else if (bytes_seen_ff == CountWidth'(1)) begin
         header_in[7:0] = item.file_byte;
      end else if (bytes_seen_ff < ({1'b0, header_ff} + HEADER_BYTES)) begin
         if (bytes_seen_ff == HEADER_BYTES) begin
            min_in = sample;
            max_in = sample;
         end else begin
            if (sample < min_ff) min_in = sample;
            if (sample > max_ff) max_in = sample;
         end
      end
      bytes_seen_in = (bytes_seen_ff < BYTES_SAT) ? bytes_seen_ff + CountWidth'(1)
                                                  : bytes_seen_ff;
   end

   always_comb begin
      result = '0;
      if (bytes_seen_in < HEADER_BYTES || bytes_seen_in > SIZE_MAX_OK) begin
         result.status = STATUS_BAD_SIZE;
      end else if (sample_end > bytes_seen_in) begin
         result.status       = STATUS_TRUNCATED;
         result.sample_count = header_in;
      end else begin
         result.sample_count = header_in;
         if (trail_full > CountWidth'(MAX_TRAILING)) begin
            result.status = STATUS_TRAILING;
         end else begin
            result.status         = STATUS_OK;
            result.trailing_count = trail_full[1:0];
            result.min_sample     = min_in;
            result.max_sample     = max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         header_ff     <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
      end else if (step_en) begin
         if (item.final_byte) begin
            // clear for the next file
            bytes_seen_ff <= '0;
            header_ff     <= '0;
            min_ff        <= '0;
            max_ff        <= '0;
         end else begin
            bytes_seen_ff <= bytes_seen_in;
            header_ff     <= header_in;
            min_ff        <= min_in;
            max_ff        <= max_in;
         end
      end
   end

endmodule

>>> src/sound_file_header_check_minmax.sv
`timescale 1ns / 1ps
// Top level: input register, per-file tracker, result register.
// Depends on sfh_pkg and sfh_track.

// Accepts one file byte per clock cycle, back to back, and returns one result
// on the byte marked final. A byte goes into the input register and is then
// folded into the byte counter, header length and sample min/max; a final
// byte's result is registered into the output register at that same step.
// The byte rate rests on sfh_track, whose counter and min/max update is
// combinational and registered once per byte. Bytes keep flowing while a
// result waits in the output register; only a second final byte stalls
// until the waiting result is taken.
module sound_file_header_check_minmax import sfh_pkg::*; #(
   parameter int MAX_TRAILING = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type hold_ff;
   logic    hold_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   rsp_type result;
   logic    out_free;
   logic    step_en;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = hold_valid_ff && (out_free || !hold_ff.final_byte);
   assign req_ready = !hold_valid_ff || step_en;

   sfh_track #(
      .MAX_TRAILING(MAX_TRAILING)
   ) u_track (
      .clock  (clock),
      .reset  (reset),
      .step_en(step_en),
      .item   (hold_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_ready) begin
         hold_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         hold_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en && hold_ff.final_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (step_en && hold_ff.final_byte) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      (step_en && hold_ff.final_byte) |=> rsp_valid_ff)
      else $error("final byte did not produce a result");

   a_stalled_byte_holds: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && !step_en) |=> (hold_valid_ff && $stable(hold_ff)))
      else $error("stalled byte lost or changed");

   a_bad_size_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_BAD_SIZE) |->
         (rsp_ff.sample_count == '0 && rsp_ff.min_sample == '0 &&
          rsp_ff.max_sample == '0))
      else $error("bad size result carries nonzero fields");

   a_error_no_trailing: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK) |-> (rsp_ff.trailing_count == '0))
      else $error("error result carries a trailing count");

endmodule
